// ===== hdl/euler_angles_to_rotation_matrix_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Euler-angle rotation matrix core
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_CORE_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EATRM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define EATRM_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define EATRM_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define EATRM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/eatrm_pkg.sv =====
// ---------------------------------------------------------------------------
// Euler-angle rotation matrix package
// Shared constants, the CORDIC arctangent table, types and rounding helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package eatrm_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 15;
  localparam int CORDIC_STEPS   = 30;
  localparam int XY_W           = 34;
  localparam int Z_W            = 33;
  localparam int Q_W            = 32;
  localparam int P_W            = 64;

  localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [Q_W-1:0]  Q30_ONE  = 32'sd1073741824;

  typedef enum logic [3:0] {
    CONV_XYX = 4'd0, CONV_XZX = 4'd1, CONV_YXY = 4'd2, CONV_YZY = 4'd3,
    CONV_ZXZ = 4'd4, CONV_ZYZ = 4'd5, CONV_XYZ = 4'd6, CONV_XZY = 4'd7,
    CONV_YXZ = 4'd8, CONV_YZX = 4'd9, CONV_ZXY = 4'd10, CONV_ZYX = 4'd11
  } conv_t;

  // Sine and cosine of one angle at Q30.
  typedef struct packed {
    logic signed [Q_W-1:0] cos_v;
    logic signed [Q_W-1:0] sin_v;
  } trig_t;

  // Arctangent of 2^-i as a fraction of a 2^32 turn.
  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0: v = 33'sd536870912;   1: v = 33'sd316933406;  2: v = 33'sd167458907;
      3: v = 33'sd85004756;    4: v = 33'sd42667331;   5: v = 33'sd21354465;
      6: v = 33'sd10679838;    7: v = 33'sd5340245;    8: v = 33'sd2670163;
      9: v = 33'sd1335087;     10: v = 33'sd667544;    11: v = 33'sd333772;
      12: v = 33'sd166886;     13: v = 33'sd83443;     14: v = 33'sd41722;
      15: v = 33'sd20861;      16: v = 33'sd10430;     17: v = 33'sd5215;
      18: v = 33'sd2608;       19: v = 33'sd1304;      20: v = 33'sd652;
      21: v = 33'sd326;        22: v = 33'sd163;       23: v = 33'sd81;
      24: v = 33'sd41;         25: v = 33'sd20;        26: v = 33'sd10;
      27: v = 33'sd5;          28: v = 33'sd3;         29: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q60 product back to Q30, half up.
  function automatic logic signed [Q_W-1:0] mul_round(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] t;
    t = p + 64'sd536870912;
    return t[Q_W+29:30];
  endfunction

endpackage

// ===== hdl/eatrm_lane.sv =====
// ---------------------------------------------------------------------------
// CORDIC sine/cosine lane
// Fully pipelined 30-step rotator, one step per stage, with quadrant fold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_angles_to_rotation_matrix_core_defines.svh"
module eatrm_lane
  import eatrm_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic                         out_valid,
  output trig_t                        trig
);

  localparam logic signed [XY_W-1:0] LIM = 34'sd1073742848;

  logic [31:0]            turn;
  logic                   flip;
  logic signed [Z_W-1:0]  z_init;

  logic signed [XY_W-1:0] x_r [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r [0:CORDIC_STEPS];
  logic                   flip_r [0:CORDIC_STEPS];
  logic                   vld_r [0:CORDIC_STEPS];
  logic                   out_valid_r;
  trig_t                  trig_r;

  // Place the angle in a 32-bit turn and fold the back half-plane forward.
  always_comb begin
    turn   = {angle, {(32-ANGLE_BITS){1'b0}}};
    flip   = turn[31] ^ turn[30];
    z_init = {turn[31] ^ flip, turn[31] ^ flip, turn[30:0]};
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= CORDIC_K;
    y_r[0]    <= '0;
    z_r[0]    <= z_init;
    flip_r[0] <= flip;
  end

  // One rotation step per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_turn(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_turn(i);
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  // Valid bits follow the data down the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 0; k < CORDIC_STEPS; k++) vld_r[k+1] <= vld_r[k];
      out_valid_r <= vld_r[CORDIC_STEPS];
    end
  end

  // Undo the fold by negating both results.
  always_ff @(posedge clk) begin
    if (flip_r[CORDIC_STEPS]) begin
      trig_r.cos_v <= Q_W'(-x_r[CORDIC_STEPS]);
      trig_r.sin_v <= Q_W'(-y_r[CORDIC_STEPS]);
    end else begin
      trig_r.cos_v <= Q_W'(x_r[CORDIC_STEPS]);
      trig_r.sin_v <= Q_W'(y_r[CORDIC_STEPS]);
    end
  end

  assign out_valid = out_valid_r;
  assign trig      = trig_r;

  `EATRM_ASSERT_IMPLY(a_cos_range, clk, rst_n, vld_r[CORDIC_STEPS], (x_r[CORDIC_STEPS] < LIM) && (x_r[CORDIC_STEPS] > -LIM))
  `EATRM_ASSERT_IMPLY(a_sin_range, clk, rst_n, vld_r[CORDIC_STEPS], (y_r[CORDIC_STEPS] < LIM) && (y_r[CORDIC_STEPS] > -LIM))
  `EATRM_ASSERT_NEXT(a_lane_flow, clk, rst_n, vld_r[CORDIC_STEPS], out_valid)

endmodule

// ===== hdl/eatrm_merge.sv =====
// ---------------------------------------------------------------------------
// Rotation matrix merge
// Forms pair and triple products of the lane results, picks the terms of
// the configured convention, then rounds and saturates each element.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_angles_to_rotation_matrix_core_defines.svh"
module eatrm_merge
  import eatrm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  trig_t                     ta,
  input  trig_t                     tb,
  input  trig_t                     tc,
  input  logic [3:0]                convention,
  output logic                      out_valid,
  output logic [8:0][FRAC_BITS:0]   m_o
);

  localparam int V_W = 34;
  localparam int O_W = FRAC_BITS + 1;
  localparam logic signed [V_W-1:0] RND = V_W'(64'sd1 <<< (29 - FRAC_BITS));
  localparam logic signed [V_W-1:0] HI  = V_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [V_W-1:0] LO  = -HI - V_W'(1);
  localparam logic [O_W-1:0]        HI_OUT = O_W'(HI);

  // Pair product slots.
  localparam int SBSC = 0, SBCC = 1, SASB = 2, CASB = 3, CACC = 4, CASC = 5;
  localparam int SACC = 6, SASC = 7, CBCC = 8, CBSC = 9, SACB = 10, CACB = 11;
  // Triple product slots.
  localparam int SACBSC = 0, SACBCC = 1, CACBSC = 2, CACBCC = 3;
  localparam int SASBCC = 4, SASBSC = 5, CASBCC = 6, CASBSC = 7;

  logic signed [Q_W-1:0] ca, sa, cb, sb, cc, sc;
  logic signed [P_W-1:0] pa_nxt [12];
  logic signed [P_W-1:0] pa_r [12];
  logic signed [Q_W-1:0] pr_r [12];
  logic signed [Q_W-1:0] pd_r [12];
  logic signed [Q_W-1:0] pe_r [12];
  logic signed [P_W-1:0] tp_r [8];
  logic signed [Q_W-1:0] tr_r [8];
  trig_t                 tb_r [4];
  trig_t                 tc_r [2];
  logic signed [V_W-1:0] v_nxt [9];
  logic signed [V_W-1:0] v_r [9];
  logic [8:0][O_W-1:0]   m_r;
  logic [5:0]            vld_r;

  assign ca = ta.cos_v;
  assign sa = ta.sin_v;
  assign cb = tb.cos_v;
  assign sb = tb.sin_v;
  assign cc = tc.cos_v;
  assign sc = tc.sin_v;

  // First multiply stage: all pair products.
  always_comb begin
    pa_nxt[SBSC] = sb * sc;  pa_nxt[SBCC] = sb * cc;  pa_nxt[SASB] = sa * sb;
    pa_nxt[CASB] = ca * sb;  pa_nxt[CACC] = ca * cc;  pa_nxt[CASC] = ca * sc;
    pa_nxt[SACC] = sa * cc;  pa_nxt[SASC] = sa * sc;  pa_nxt[CBCC] = cb * cc;
    pa_nxt[CBSC] = cb * sc;  pa_nxt[SACB] = sa * cb;  pa_nxt[CACB] = ca * cb;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 12; k++) begin
      pa_r[k] <= pa_nxt[k];
      pr_r[k] <= mul_round(pa_r[k]);
      pd_r[k] <= pr_r[k];
      pe_r[k] <= pd_r[k];
    end
    tb_r[0] <= tb;
    for (int k = 0; k < 3; k++) tb_r[k+1] <= tb_r[k];
    tc_r[0] <= tc;
    tc_r[1] <= tc_r[0];
  end

  // Second multiply stage: pair results by the third angle's terms.
  always_ff @(posedge clk) begin
    tp_r[SACBSC] <= P_W'(pr_r[SACB]) * P_W'(tc_r[1].sin_v);
    tp_r[SACBCC] <= P_W'(pr_r[SACB]) * P_W'(tc_r[1].cos_v);
    tp_r[CACBSC] <= P_W'(pr_r[CACB]) * P_W'(tc_r[1].sin_v);
    tp_r[CACBCC] <= P_W'(pr_r[CACB]) * P_W'(tc_r[1].cos_v);
    tp_r[SASBCC] <= P_W'(pr_r[SASB]) * P_W'(tc_r[1].cos_v);
    tp_r[SASBSC] <= P_W'(pr_r[SASB]) * P_W'(tc_r[1].sin_v);
    tp_r[CASBCC] <= P_W'(pr_r[CASB]) * P_W'(tc_r[1].cos_v);
    tp_r[CASBSC] <= P_W'(pr_r[CASB]) * P_W'(tc_r[1].sin_v);
    for (int k = 0; k < 8; k++) tr_r[k] <= mul_round(tp_r[k]);
  end

  // Term selection for the configured convention.
  always_comb begin
    logic signed [V_W-1:0] q2 [12];
    logic signed [V_W-1:0] q3 [8];
    logic signed [V_W-1:0] cbv, sbv;
    for (int k = 0; k < 12; k++) q2[k] = V_W'(pe_r[k]);
    for (int k = 0; k < 8; k++) q3[k] = V_W'(tr_r[k]);
    cbv = V_W'(tb_r[3].cos_v);
    sbv = V_W'(tb_r[3].sin_v);
    case (convention)
      CONV_XYX: begin
        v_nxt[0] = cbv;               v_nxt[1] = q2[SBSC];           v_nxt[2] = q2[SBCC];
        v_nxt[3] = q2[SASB];          v_nxt[4] = q2[CACC] - q3[SACBSC];
        v_nxt[5] = -q2[CASC] - q3[SACBCC];                           v_nxt[6] = -q2[CASB];
        v_nxt[7] = q2[SACC] + q3[CACBSC];                            v_nxt[8] = q3[CACBCC] - q2[SASC];
      end
      CONV_XZX: begin
        v_nxt[0] = cbv;               v_nxt[1] = -q2[SBCC];          v_nxt[2] = q2[SBSC];
        v_nxt[3] = q2[CASB];          v_nxt[4] = q3[CACBCC] - q2[SASC];
        v_nxt[5] = -q2[SACC] - q3[CACBSC];                           v_nxt[6] = q2[SASB];
        v_nxt[7] = q2[CASC] + q3[SACBCC];                            v_nxt[8] = q2[CACC] - q3[SACBSC];
      end
      CONV_YXY: begin
        v_nxt[0] = q2[CACC] - q3[SACBSC];  v_nxt[1] = q2[SASB];
        v_nxt[2] = q2[CASC] + q3[SACBCC];  v_nxt[3] = q2[SBSC];
        v_nxt[4] = cbv;                    v_nxt[5] = -q2[SBCC];
        v_nxt[6] = -q2[SACC] - q3[CACBSC]; v_nxt[7] = q2[CASB];
        v_nxt[8] = q3[CACBCC] - q2[SASC];
      end
      CONV_YZY: begin
        v_nxt[0] = q3[CACBCC] - q2[SASC];  v_nxt[1] = -q2[CASB];
        v_nxt[2] = q2[SACC] + q3[CACBSC];  v_nxt[3] = q2[SBCC];
        v_nxt[4] = cbv;                    v_nxt[5] = q2[SBSC];
        v_nxt[6] = -q2[CASC] - q3[SACBCC]; v_nxt[7] = q2[SASB];
        v_nxt[8] = q2[CACC] - q3[SACBSC];
      end
      CONV_ZXZ: begin
        v_nxt[0] = q2[CACC] - q3[SACBSC];  v_nxt[1] = -q2[CASC] - q3[SACBCC];
        v_nxt[2] = q2[SASB];               v_nxt[3] = q2[SACC] + q3[CACBSC];
        v_nxt[4] = q3[CACBCC] - q2[SASC];  v_nxt[5] = -q2[CASB];
        v_nxt[6] = q2[SBSC];               v_nxt[7] = q2[SBCC];
        v_nxt[8] = cbv;
      end
      CONV_ZYZ: begin
        v_nxt[0] = q3[CACBCC] - q2[SASC];  v_nxt[1] = -q2[SACC] - q3[CACBSC];
        v_nxt[2] = q2[CASB];               v_nxt[3] = q2[CASC] + q3[SACBCC];
        v_nxt[4] = q2[CACC] - q3[SACBSC];  v_nxt[5] = q2[SASB];
        v_nxt[6] = -q2[SBCC];              v_nxt[7] = q2[SBSC];
        v_nxt[8] = cbv;
      end
      CONV_XYZ: begin
        v_nxt[0] = q2[CBCC];               v_nxt[1] = -q2[CBSC];
        v_nxt[2] = sbv;                    v_nxt[3] = q2[CASC] + q3[SASBCC];
        v_nxt[4] = q2[CACC] - q3[SASBSC];  v_nxt[5] = -q2[SACB];
        v_nxt[6] = q2[SASC] - q3[CASBCC];  v_nxt[7] = q2[SACC] + q3[CASBSC];
        v_nxt[8] = q2[CACB];
      end
      CONV_XZY: begin
        v_nxt[0] = q2[CBCC];               v_nxt[1] = -sbv;
        v_nxt[2] = q2[CBSC];               v_nxt[3] = q2[SASC] + q3[CASBCC];
        v_nxt[4] = q2[CACB];               v_nxt[5] = q3[CASBSC] - q2[SACC];
        v_nxt[6] = q3[SASBCC] - q2[CASC];  v_nxt[7] = q2[SACB];
        v_nxt[8] = q2[CACC] + q3[SASBSC];
      end
      CONV_YXZ: begin
        v_nxt[0] = q2[CACC] + q3[SASBSC];  v_nxt[1] = q3[SASBCC] - q2[CASC];
        v_nxt[2] = q2[SACB];               v_nxt[3] = q2[CBSC];
        v_nxt[4] = q2[CBCC];               v_nxt[5] = -sbv;
        v_nxt[6] = q3[CASBSC] - q2[SACC];  v_nxt[7] = q3[CASBCC] + q2[SASC];
        v_nxt[8] = q2[CACB];
      end
      CONV_YZX: begin
        v_nxt[0] = q2[CACB];               v_nxt[1] = q2[SASC] - q3[CASBCC];
        v_nxt[2] = q2[SACC] + q3[CASBSC];  v_nxt[3] = sbv;
        v_nxt[4] = q2[CBCC];               v_nxt[5] = -q2[CBSC];
        v_nxt[6] = -q2[SACB];              v_nxt[7] = q2[CASC] + q3[SASBCC];
        v_nxt[8] = q2[CACC] - q3[SASBSC];
      end
      CONV_ZXY: begin
        v_nxt[0] = q2[CACC] - q3[SASBSC];  v_nxt[1] = -q2[SACB];
        v_nxt[2] = q2[CASC] + q3[SASBCC];  v_nxt[3] = q2[SACC] + q3[CASBSC];
        v_nxt[4] = q2[CACB];               v_nxt[5] = q2[SASC] - q3[CASBCC];
        v_nxt[6] = -q2[CBSC];              v_nxt[7] = sbv;
        v_nxt[8] = q2[CBCC];
      end
      CONV_ZYX: begin
        v_nxt[0] = q2[CACB];               v_nxt[1] = q3[CASBSC] - q2[SACC];
        v_nxt[2] = q2[SASC] + q3[CASBCC];  v_nxt[3] = q2[SACB];
        v_nxt[4] = q2[CACC] + q3[SASBSC];  v_nxt[5] = q3[SASBCC] - q2[CASC];
        v_nxt[6] = -sbv;                   v_nxt[7] = q2[CBSC];
        v_nxt[8] = q2[CBCC];
      end
      default: begin
        // Unknown convention: identity matrix.
        for (int k = 0; k < 9; k++) v_nxt[k] = '0;
        v_nxt[0] = V_W'(Q30_ONE);
        v_nxt[4] = V_W'(Q30_ONE);
        v_nxt[8] = V_W'(Q30_ONE);
      end
    endcase
  end

  // Round to the output format and saturate.
  always_ff @(posedge clk) begin
    logic signed [V_W-1:0] r;
    for (int k = 0; k < 9; k++) begin
      v_r[k] <= v_nxt[k];
      r = (v_r[k] + RND) >>> (30 - FRAC_BITS);
      if (r > HI) m_r[k] <= O_W'(HI);
      else if (r < LO) m_r[k] <= O_W'(LO);
      else m_r[k] <= r[O_W-1:0];
    end
  end

  // Valid bits across the six merge stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  assign out_valid = vld_r[5];
  assign m_o       = m_r;

  `EATRM_ASSERT_IMPLY(a_identity_diag, clk, rst_n, out_valid && (convention > CONV_ZYX), m_o[0] == HI_OUT)
  `EATRM_ASSERT_IMPLY(a_identity_off, clk, rst_n, out_valid && (convention > CONV_ZYX), m_o[1] == '0)
  `EATRM_ASSERT_NEXT(a_strobe_flow, clk, rst_n, vld_r[4], out_valid)

endmodule

// ===== hdl/euler_angles_to_rotation_matrix_core.sv =====
// Throughput: one request per cycle; busy is always low and the receiver cannot stall.
// Latency is set by the 32 lane stages and the six merge stages; every stage takes a new request each cycle.
// Reset: synchronous active-low rst_n clears all valid bits and sets convention to 0.
// ---------------------------------------------------------------------------
// Euler-angle rotation matrix core
// Three CORDIC lanes, one per angle, feed a merge stage that builds the
// 3x3 rotation matrix for one of twelve conventions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix_core
  import eatrm_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ANGLE_BITS-1:0] in_angle_first,
  input  logic signed [ANGLE_BITS-1:0] in_angle_second,
  input  logic signed [ANGLE_BITS-1:0] in_angle_third,
  output logic                         out_strobe,
  output logic signed [FRAC_BITS:0]    out_m00,
  output logic signed [FRAC_BITS:0]    out_m01,
  output logic signed [FRAC_BITS:0]    out_m02,
  output logic signed [FRAC_BITS:0]    out_m10,
  output logic signed [FRAC_BITS:0]    out_m11,
  output logic signed [FRAC_BITS:0]    out_m12,
  output logic signed [FRAC_BITS:0]    out_m20,
  output logic signed [FRAC_BITS:0]    out_m21,
  output logic signed [FRAC_BITS:0]    out_m22,
  input  logic                         cfg_we,
  input  logic [3:0]                   cfg_data
);

  logic [3:0]               convention_r;
  logic [2:0]               lane_vld;
  trig_t                    trig_a, trig_b, trig_c;
  logic [8:0][FRAC_BITS:0]  m;

  // Convention register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convention_r <= CONV_XYX;
    end else if (cfg_we) begin
      convention_r <= cfg_data;
    end
  end

  // The pipeline takes a request every cycle.
  assign busy = 1'b0;

  eatrm_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_a (
    .clk(clk), .rst_n(rst_n), .in_valid(start), .angle(in_angle_first),
    .out_valid(lane_vld[0]), .trig(trig_a)
  );

  eatrm_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_b (
    .clk(clk), .rst_n(rst_n), .in_valid(start), .angle(in_angle_second),
    .out_valid(lane_vld[1]), .trig(trig_b)
  );

  eatrm_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_c (
    .clk(clk), .rst_n(rst_n), .in_valid(start), .angle(in_angle_third),
    .out_valid(lane_vld[2]), .trig(trig_c)
  );

  eatrm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .in_valid(&lane_vld),
    .ta(trig_a), .tb(trig_b), .tc(trig_c), .convention(convention_r),
    .out_valid(out_strobe), .m_o(m)
  );

  assign out_m00 = m[0];
  assign out_m01 = m[1];
  assign out_m02 = m[2];
  assign out_m10 = m[3];
  assign out_m11 = m[4];
  assign out_m12 = m[5];
  assign out_m20 = m[6];
  assign out_m21 = m[7];
  assign out_m22 = m[8];

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// Testbench for the Euler-angle rotation matrix core
// Drives angle triples through every convention code, predicts each matrix
// with a bit-exact CORDIC and rounding model, and checks every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top
  import eatrm_pkg::*;
();

  localparam int  AW          = 16;
  localparam int  FW          = 15;
  localparam int  LATENCY     = 38;
  localparam int  N_RANDOM    = 1450;
  localparam int  CYCLE_LIMIT = 200000;
  localparam logic [3:0] CONV_IDENTITY = 4'd12;
  localparam logic [3:0] CONV_TOP      = 4'd15;

  typedef struct {
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic signed [AW-1:0] c;
  } angles_t;

  typedef struct {
    logic signed [FW:0] m [9];
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [AW-1:0] in_angle_first = '0;
  logic signed [AW-1:0] in_angle_second = '0;
  logic signed [AW-1:0] in_angle_third = '0;
  logic out_strobe;
  logic signed [FW:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [FW:0] out_m20, out_m21, out_m22;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;

  angles_t pending_angles[$];
  matrix_t expected_matrices[$];
  logic [3:0] convention_model = CONV_XYX;
  int sender_idle_pct = 0;
  int errors = 0;
  int results_seen = 0;
  int cycle_count = 0;

  euler_angles_to_rotation_matrix_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_angle_first(in_angle_first), .in_angle_second(in_angle_second),
    .in_angle_third(in_angle_third), .out_strobe(out_strobe),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Clock generation.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Floor shift right of a signed value.
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // Product of two Q30 values, rounded half up.
  function automatic longint qmul(longint p, longint q);
    return fshr(p * q + 64'sd536870912, 30);
  endfunction

  function automatic longint qmul3(longint p, longint q, longint r);
    return qmul(qmul(p, q), r);
  endfunction

  // Cosine and sine at Q30 by a 30-step CORDIC with quadrant folding.
  function automatic void cordic(logic [AW-1:0] ang, output longint co, output longint si);
    logic [31:0] u;
    logic flip;
    longint x, y, z, dx, dy;
    u = {ang, {(32 - AW){1'b0}}};
    flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
    if (flip) u[31] = ~u[31];
    x = CORDIC_K;
    y = 0;
    z = longint'(signed'(u));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endfunction

  // Round a Q30 element to Q1.15 and saturate.
  function automatic logic signed [FW:0] to_q15(longint v);
    longint r;
    r = fshr(v + (64'sd1 <<< (29 - FW)), 30 - FW);
    if (r > (2 ** FW) - 1) r = (2 ** FW) - 1;
    if (r < -(2 ** FW)) r = -(2 ** FW);
    return r[FW:0];
  endfunction

  // Rotation matrix for one angle triple under the current convention.
  function automatic matrix_t rotation_matrix(angles_t ang, logic [3:0] conv);
    longint ca, sa, cb, sb, cc, sc;
    longint m [9];
    matrix_t res;
    cordic(ang.a, ca, sa);
    cordic(ang.b, cb, sb);
    cordic(ang.c, cc, sc);
    case (conv)
      CONV_XYX: m = '{cb, qmul(sb, sc), qmul(sb, cc),
        qmul(sa, sb), qmul(ca, cc) - qmul3(sa, cb, sc), -qmul(ca, sc) - qmul3(sa, cb, cc),
        -qmul(ca, sb), qmul(sa, cc) + qmul3(ca, cb, sc), qmul3(ca, cb, cc) - qmul(sa, sc)};
      CONV_XZX: m = '{cb, -qmul(sb, cc), qmul(sb, sc),
        qmul(ca, sb), qmul3(ca, cb, cc) - qmul(sa, sc), -qmul(sa, cc) - qmul3(ca, cb, sc),
        qmul(sa, sb), qmul(ca, sc) + qmul3(sa, cb, cc), qmul(ca, cc) - qmul3(sa, cb, sc)};
      CONV_YXY: m = '{qmul(ca, cc) - qmul3(sa, cb, sc), qmul(sa, sb),
        qmul(ca, sc) + qmul3(sa, cb, cc), qmul(sb, sc), cb, -qmul(sb, cc),
        -qmul(sa, cc) - qmul3(ca, cb, sc), qmul(ca, sb), qmul3(ca, cb, cc) - qmul(sa, sc)};
      CONV_YZY: m = '{qmul3(ca, cb, cc) - qmul(sa, sc), -qmul(ca, sb),
        qmul(sa, cc) + qmul3(ca, cb, sc), qmul(sb, cc), cb, qmul(sb, sc),
        -qmul(ca, sc) - qmul3(sa, cb, cc), qmul(sa, sb), qmul(ca, cc) - qmul3(sa, cb, sc)};
      CONV_ZXZ: m = '{qmul(ca, cc) - qmul3(sa, cb, sc), -qmul(ca, sc) - qmul3(sa, cb, cc),
        qmul(sa, sb), qmul(sa, cc) + qmul3(ca, cb, sc), qmul3(ca, cb, cc) - qmul(sa, sc),
        -qmul(ca, sb), qmul(sb, sc), qmul(sb, cc), cb};
      CONV_ZYZ: m = '{qmul3(ca, cb, cc) - qmul(sa, sc), -qmul(sa, cc) - qmul3(ca, cb, sc),
        qmul(ca, sb), qmul(ca, sc) + qmul3(sa, cb, cc), qmul(ca, cc) - qmul3(sa, cb, sc),
        qmul(sa, sb), -qmul(sb, cc), qmul(sb, sc), cb};
      CONV_XYZ: m = '{qmul(cb, cc), -qmul(cb, sc), sb,
        qmul(ca, sc) + qmul3(sa, sb, cc), qmul(ca, cc) - qmul3(sa, sb, sc), -qmul(sa, cb),
        qmul(sa, sc) - qmul3(ca, sb, cc), qmul(sa, cc) + qmul3(ca, sb, sc), qmul(ca, cb)};
      CONV_XZY: m = '{qmul(cb, cc), -sb, qmul(cb, sc),
        qmul(sa, sc) + qmul3(ca, sb, cc), qmul(ca, cb), qmul3(ca, sb, sc) - qmul(sa, cc),
        qmul3(sa, sb, cc) - qmul(ca, sc), qmul(sa, cb), qmul(ca, cc) + qmul3(sa, sb, sc)};
      CONV_YXZ: m = '{qmul(ca, cc) + qmul3(sa, sb, sc), qmul3(sa, sb, cc) - qmul(ca, sc),
        qmul(sa, cb), qmul(cb, sc), qmul(cb, cc), -sb,
        qmul3(ca, sb, sc) - qmul(sa, cc), qmul3(ca, sb, cc) + qmul(sa, sc), qmul(ca, cb)};
      CONV_YZX: m = '{qmul(ca, cb), qmul(sa, sc) - qmul3(ca, sb, cc),
        qmul(sa, cc) + qmul3(ca, sb, sc), sb, qmul(cb, cc), -qmul(cb, sc),
        -qmul(sa, cb), qmul(ca, sc) + qmul3(sa, sb, cc), qmul(ca, cc) - qmul3(sa, sb, sc)};
      CONV_ZXY: m = '{qmul(ca, cc) - qmul3(sa, sb, sc), -qmul(sa, cb),
        qmul(ca, sc) + qmul3(sa, sb, cc), qmul(sa, cc) + qmul3(ca, sb, sc), qmul(ca, cb),
        qmul(sa, sc) - qmul3(ca, sb, cc), -qmul(cb, sc), sb, qmul(cb, cc)};
      CONV_ZYX: m = '{qmul(ca, cb), qmul3(ca, sb, sc) - qmul(sa, cc),
        qmul(sa, sc) + qmul3(ca, sb, cc), qmul(sa, cb), qmul(ca, cc) + qmul3(sa, sb, sc),
        qmul3(sa, sb, cc) - qmul(ca, sc), -sb, qmul(cb, sc), qmul(cb, cc)};
      default: m = '{Q30_ONE, 0, 0, 0, Q30_ONE, 0, 0, 0, Q30_ONE};
    endcase
    for (int k = 0; k < 9; k++) res.m[k] = to_q15(m[k]);
    return res;
  endfunction

  function automatic angles_t rand_angles();
    angles_t r;
    logic signed [AW-1:0] corner [6];
    corner = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, 16'shc000, 16'shffff};
    r.a = ($urandom_range(0, 9) == 0) ? corner[$urandom_range(0, 5)] : AW'($urandom);
    r.b = ($urandom_range(0, 9) == 0) ? corner[$urandom_range(0, 5)] : AW'($urandom);
    r.c = ($urandom_range(0, 9) == 0) ? corner[$urandom_range(0, 5)] : AW'($urandom);
    return r;
  endfunction

  // Driver: presents queued requests, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Hold the request until it is taken.
    end else if (pending_angles.size() > 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct) begin
      angles_t nxt;
      nxt = pending_angles.pop_front();
      start <= 1'b1;
      in_angle_first <= nxt.a;
      in_angle_second <= nxt.b;
      in_angle_third <= nxt.c;
      expected_matrices.push_back(rotation_matrix(nxt, convention_model));
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: compares each strobed matrix with the oldest prediction.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_strobe) begin
      logic signed [FW:0] got [9];
      string fname [9];
      matrix_t exp_m;
      got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21, out_m22};
      fname = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
      results_seen <= results_seen + 1;
      if (expected_matrices.size() == 0) begin
        $error("matrix result with no request outstanding");
        errors = errors + 1;
      end else begin
        exp_m = expected_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== exp_m.m[k]) begin
            $error("%s: expected %0d, got %0d", fname[k], exp_m.m[k], got[k]);
            errors = errors + 1;
          end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain();
    while (pending_angles.size() > 0 || start || expected_matrices.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_convention(logic [3:0] conv);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= conv;
    convention_model = conv;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    angles_t d;
    logic [3:0] conv_plan [];
    int idle_plan [4];
    int per_phase;
    idle_plan = '{0, 70, 0, 20};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset convention, extremes of every angle, quarter turns.
    for (int k = 0; k < 12; k++) begin
      logic signed [AW-1:0] v [6];
      v = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, 16'shc000, 16'sh5555};
      d.a = v[k % 6]; d.b = v[(k + 1) % 6]; d.c = v[(k + 3) % 6];
      pending_angles.push_back(d);
    end
    d.a = 16'shaaaa; d.b = 16'sh5555; d.c = 16'shaaaa;
    pending_angles.push_back(d);
    drain();

    // Every convention code once, unknown ones included, with zero angles and one mixed triple.
    for (int cv = 0; cv < 16; cv++) begin
      write_convention(4'(cv));
      d.a = 16'sh0000; d.b = 16'sh0000; d.c = 16'sh0000;
      pending_angles.push_back(d);
      d.a = 16'sh2000; d.b = 16'sh7fff; d.c = 16'sh8000;
      pending_angles.push_back(d);
      drain();
    end

    // Random phases over random convention codes, extremes first, with varied idling.
    conv_plan = new[20];
    conv_plan[0] = CONV_XYX;
    conv_plan[1] = CONV_TOP;
    conv_plan[2] = CONV_ZYX;
    conv_plan[3] = CONV_IDENTITY;
    for (int p = 4; p < 20; p++) conv_plan[p] = 4'($urandom_range(0, 15));
    per_phase = N_RANDOM / 20;
    for (int p = 0; p < 20; p++) begin
      write_convention(conv_plan[p]);
      sender_idle_pct = idle_plan[p % 4];
      for (int k = 0; k < per_phase; k++) pending_angles.push_back(rand_angles());
      drain();
    end

    $display("Checked %0d matrices over all 16 convention codes,", results_seen);
    $display("with angle extremes, quarter turns and random idle gaps.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/eatrm_pkg.sv
hdl/eatrm_lane.sv
hdl/eatrm_merge.sv
hdl/euler_angles_to_rotation_matrix_core.sv
bench/tb_top.sv
